>>> hw/rtl/top_k_largest_tracker_macros.svh
// assertion helpers shared by the tracker modules
`ifndef TOP_K_LARGEST_TRACKER_MACROS_SVH
`define TOP_K_LARGEST_TRACKER_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define TKLT_ASSERT_NOW(lbl, clk, rstn, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cond)) \
        else $error("tracker check failed");

// condition must hold in the cycle after the trigger
`define TKLT_ASSERT_NEXT(lbl, clk, rstn, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error("tracker check failed");

`endif

>>> hw/rtl/tklt_pkg.sv
`default_nettype none

package tklt_pkg;

    localparam int SIZE_W = 48;
    localparam int TAG_W  = 32;
    localparam int RANK_W = 5;
    localparam int OP_W   = 2;
    localparam int KL_W   = 6;
    // wide enough for any count and for the keep limit register
    localparam int LIM_W  = 7;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    localparam int MAX_KEEP_DEF = 32;
    localparam int TAG_BITS_DEF = 32;

    localparam logic [KL_W-1:0]   DEF_KEEP_LIMIT = 6'd20;
    localparam logic [SIZE_W-1:0] DEF_MIN_SIZE   = 48'd104857600;

    localparam logic [OP_W-1:0] OP_OFFER = 2'd0;
    localparam logic [OP_W-1:0] OP_DUMP  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic REG_KEEP_LIMIT = 1'b0;
    localparam logic REG_MIN_SIZE   = 1'b1;

    typedef struct packed {
        logic offer;
        logic clear;
        logic dump_start;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic done;
    } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/tklt_ctrl.sv
`default_nettype none
`include "top_k_largest_tracker_macros.svh"

module tklt_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    input  wire logic [tklt_pkg::OP_W-1:0] in_op,
    output logic                           in_ready,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output tklt_pkg::cmd_t                 cmd,
    input  wire tklt_pkg::sts_t            sts
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb begin
        cmd.offer      = accept && (in_op == tklt_pkg::OP_OFFER);
        cmd.clear      = accept && (in_op == tklt_pkg::OP_CLEAR);
        cmd.dump_start = accept && (in_op == tklt_pkg::OP_DUMP);
        cmd.load       = (state_reg == ST_DUMP) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.dump_start) begin
                    state_next = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (cmd.load && sts.done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TKLT_ASSERT_NOW(a_load_only_when_free, aclk, aresetn, cmd.load, out_free)
    `TKLT_ASSERT_NEXT(a_load_shows_item, aclk, aresetn, cmd.load, out_valid_reg)
    `TKLT_ASSERT_NOW(a_busy_in_dump, aclk, aresetn, state_reg == ST_DUMP, !in_ready)

endmodule

`default_nettype wire

>>> hw/rtl/tklt_dp.sv
`default_nettype none
`include "top_k_largest_tracker_macros.svh"

module tklt_dp #(
    parameter int MAX_KEEP = tklt_pkg::MAX_KEEP_DEF,
    parameter int TAG_BITS = tklt_pkg::TAG_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tklt_pkg::cmd_t                cmd,
    output tklt_pkg::sts_t                     sts,
    input  wire logic [tklt_pkg::KL_W-1:0]     keep_limit,
    input  wire logic [tklt_pkg::SIZE_W-1:0]   min_size,
    input  wire logic [tklt_pkg::SIZE_W-1:0]   in_size,
    input  wire logic [tklt_pkg::TAG_W-1:0]    in_tag,
    output logic [tklt_pkg::RANK_W-1:0]        out_rank,
    output logic [tklt_pkg::SIZE_W-1:0]        out_size,
    output logic [tklt_pkg::TAG_W-1:0]         out_tag,
    output logic                               out_empty,
    output logic                               out_last
);

    localparam int CNT_W  = $clog2(MAX_KEEP + 1);
    localparam int IDX_W  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int STAG_W = (TAG_BITS < tklt_pkg::TAG_W) ? TAG_BITS : tklt_pkg::TAG_W;
    localparam int LIM_W  = tklt_pkg::LIM_W;

    // sorted cell chain, largest first
    logic [tklt_pkg::SIZE_W-1:0] size_reg [MAX_KEEP];
    logic [STAG_W-1:0]           tag_reg  [MAX_KEEP];
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            count_inc;
    logic [IDX_W-1:0]            rank_reg, rank_next;

    logic [tklt_pkg::RANK_W-1:0] out_rank_reg;
    logic [tklt_pkg::SIZE_W-1:0] out_size_reg;
    logic [STAG_W-1:0]           out_tag_reg;
    logic                        out_empty_reg;
    logic                        out_last_reg;

    logic [MAX_KEEP-1:0] ge;      // held entry at least as large as the offer
    logic [MAX_KEEP-1:0] lt;      // held entry smaller than the offer
    logic [MAX_KEEP-1:0] prev_ge;
    logic [STAG_W-1:0]   tag_in;
    logic [LIM_W-1:0]    cnt_ext;
    logic                room;
    logic                qualifies;
    logic                insert;
    logic                list_empty;
    logic                at_last;

    assign tag_in     = STAG_W'(in_tag);
    assign cnt_ext    = LIM_W'(count_reg);
    assign count_inc  = CNT_W'(count_reg + CNT_W'(1));
    assign room       = (cnt_ext < LIM_W'(keep_limit)) && (cnt_ext < LIM_W'(MAX_KEEP));
    assign qualifies  = (keep_limit != '0) && (in_size >= min_size);
    assign insert     = cmd.offer && qualifies && (room || (|lt));
    assign list_empty = (count_reg == '0);
    assign at_last    = (CNT_W'(rank_reg) + CNT_W'(1)) == count_reg;
    assign sts.done   = list_empty || at_last;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEEP; gi++) begin : g_cell
            logic held;
            logic geq;
            assign held     = count_reg > CNT_W'(gi);
            assign geq      = size_reg[gi] >= in_size;
            assign ge[gi]   = held && geq;
            assign lt[gi]   = held && !geq;
            if (gi == 0) begin : g_head
                assign prev_ge[gi] = 1'b1;
                always_ff @(posedge aclk) begin
                    if (insert && !ge[gi]) begin
                        size_reg[gi] <= in_size;
                        tag_reg[gi]  <= tag_in;
                    end
                end
            end else begin : g_body
                assign prev_ge[gi] = ge[gi-1];
                // first cell past the entries at least as large takes the offer, the rest shift down
                always_ff @(posedge aclk) begin
                    if (insert && !ge[gi]) begin
                        if (prev_ge[gi]) begin
                            size_reg[gi] <= in_size;
                            tag_reg[gi]  <= tag_in;
                        end else begin
                            size_reg[gi] <= size_reg[gi-1];
                            tag_reg[gi]  <= tag_reg[gi-1];
                        end
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        priority if (cmd.clear) begin
            count_next = '0;
        end else if (insert && room) begin
            count_next = count_inc;
        end
    end

    always_comb begin
        rank_next = rank_reg;
        priority if (cmd.dump_start) begin
            rank_next = '0;
        end else if (cmd.load) begin
            rank_next = IDX_W'(rank_reg + IDX_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            rank_reg  <= '0;
        end else begin
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_empty_reg <= list_empty;
            out_last_reg  <= list_empty || at_last;
            if (list_empty) begin
                out_rank_reg <= '0;
                out_size_reg <= '0;
                out_tag_reg  <= '0;
            end else begin
                out_rank_reg <= tklt_pkg::RANK_W'(rank_reg);
                out_size_reg <= size_reg[rank_reg];
                out_tag_reg  <= tag_reg[rank_reg];
            end
        end
    end

    assign out_rank  = out_rank_reg;
    assign out_size  = out_size_reg;
    assign out_tag   = tklt_pkg::TAG_W'(out_tag_reg);
    assign out_empty = out_empty_reg;
    assign out_last  = out_last_reg;

    `TKLT_ASSERT_NOW(a_count_in_range, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_KEEP))
    `TKLT_ASSERT_NEXT(a_clear_empties, aclk, aresetn, cmd.clear, count_reg == '0)
    `TKLT_ASSERT_NEXT(a_insert_grows, aclk, aresetn, insert && room, count_reg == $past(count_inc))

endmodule

`default_nettype wire

>>> hw/rtl/top_k_largest_tracker.sv
// top_k_largest_tracker: keeps the largest offered items, sorted largest first
//
// input channel (s_): one item per handshake; s_tuser carries the operation
//   (offer, dump, clear), s_tdata the size and tag of an offer
// result channel (m_): one item per held entry on a dump, largest first,
//   m_tlast on the final one; a dump of an empty list gives one item
//   flagged empty in m_tuser
// apb port: keep_limit at 0x0, min_size at 0x8, 64-bit data, pready tied high
//
// offer and clear produce nothing, so back-to-back offers run at one item per cycle
//   through the compare-and-shift cell chain
// a dump holds s_tready low until its last result is loaded and gives one result
//   per cycle while the receiver keeps up, out of a single output register; the
//   first result shows once the sequencer has entered its dump state and loaded it
// a stalled receiver freezes the dump; new input waits until the dump's last
//   result is loaded, while an already loaded result may still be pending
// reset empties the list and restores keep_limit 20 and min_size 100 MiB;
//   the entry storage itself is not cleared
`default_nettype none

module top_k_largest_tracker #(
    parameter int MAX_KEEP = tklt_pkg::MAX_KEEP_DEF,
    parameter int TAG_BITS = tklt_pkg::TAG_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input channel
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [79:0]                    s_tdata,  // item_size[47:0], item_tag[79:48]
    input  wire logic [1:0]                     s_tuser,  // operation[1:0]
    // result channel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [87:0]                         m_tdata,  // rank[4:0], entry_size[52:5],
                                                          // entry_tag[84:53], zero[87:85]
    output logic [0:0]                          m_tuser,  // is_empty[0]
    output logic                                m_tlast,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tklt_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tklt_pkg::PDATA_W-1:0]   pwdata,
    output logic [tklt_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    logic [tklt_pkg::KL_W-1:0]   keep_limit_reg, keep_limit_next;
    logic [tklt_pkg::SIZE_W-1:0] min_size_reg, min_size_next;
    logic                        cfg_write;
    logic                        reg_sel;

    tklt_pkg::cmd_t cmd;
    tklt_pkg::sts_t sts;

    logic [tklt_pkg::RANK_W-1:0] out_rank;
    logic [tklt_pkg::SIZE_W-1:0] out_size;
    logic [tklt_pkg::TAG_W-1:0]  out_tag;
    logic                        out_empty;
    logic                        out_last;

    // register select: one 64-bit slot per register, low address bits ignored
    assign reg_sel   = paddr[3];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        keep_limit_next = keep_limit_reg;
        min_size_next   = min_size_reg;
        if (cfg_write) begin
            unique case (reg_sel)
                tklt_pkg::REG_KEEP_LIMIT: keep_limit_next = pwdata[tklt_pkg::KL_W-1:0];
                tklt_pkg::REG_MIN_SIZE:   min_size_next   = pwdata[tklt_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_limit_reg <= tklt_pkg::DEF_KEEP_LIMIT;
            min_size_reg   <= tklt_pkg::DEF_MIN_SIZE;
        end else begin
            keep_limit_reg <= keep_limit_next;
            min_size_reg   <= min_size_next;
        end
    end

    always_comb begin
        unique case (reg_sel)
            tklt_pkg::REG_KEEP_LIMIT: prdata = tklt_pkg::PDATA_W'(keep_limit_reg);
            tklt_pkg::REG_MIN_SIZE:   prdata = tklt_pkg::PDATA_W'(min_size_reg);
            default:                  prdata = '0;
        endcase
    end

    // sequencer: handshakes, dump walk, output valid
    tklt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // cell chain, entry count and output register
    tklt_dp #(
        .MAX_KEEP (MAX_KEEP),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .keep_limit (keep_limit_reg),
        .min_size   (min_size_reg),
        .in_size    (s_tdata[47:0]),
        .in_tag     (s_tdata[79:48]),
        .out_rank   (out_rank),
        .out_size   (out_size),
        .out_tag    (out_tag),
        .out_empty  (out_empty),
        .out_last   (out_last)
    );

    assign m_tdata = {3'b000, out_tag, out_size, out_rank};
    assign m_tuser = out_empty;
    assign m_tlast = out_last;

endmodule

`default_nettype wire

>>> tb/top_k_largest_tracker_tb.sv
module top_k_largest_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tklt_pkg::*;

    // operation code the block must ignore
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
    // chance in a hundred that a side idles in a cycle
    localparam int IDLE_PCT = 16;
    // cycles without any handshake before the run is given up
    localparam int STALL_LIMIT = 5000;
    // an offer or clear settles in the cycle after it is taken
    localparam int SETTLE_CYCLES = 4;
    localparam int FINAL_CYCLES = 20;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } tracker_item_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
        logic              is_empty;
        logic              last;
    } entry_result_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // input channel
    logic               s_tvalid = 1'b0;
    wire                s_tready;
    logic [79:0]        s_tdata  = '0;   // item_size[47:0], item_tag[79:48]
    logic [1:0]         s_tuser  = '0;   // operation[1:0]

    // result channel
    wire                m_tvalid;
    logic               m_tready = 1'b0;
    wire  [87:0]        m_tdata;          // rank[4:0], entry_size[52:5], entry_tag[84:53]
    wire  [0:0]         m_tuser;          // is_empty[0]
    wire                m_tlast;

    // configuration port
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    wire  [PDATA_W-1:0] prdata;
    wire                pready;

    top_k_largest_tracker i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // items waiting to be driven and dump results still to arrive
    tracker_item_t pending_items[$];
    entry_result_t dump_results_q[$];
    tracker_item_t next_item;
    entry_result_t want;

    // predicted contents of the list, largest first
    logic [SIZE_W-1:0] held_sizes [MAX_KEEP_DEF];
    logic [TAG_W-1:0]  held_tags  [MAX_KEEP_DEF];
    int                held_count = 0;

    // predicted register values
    int                cfg_keep_limit = int'(DEF_KEEP_LIMIT);
    logic [SIZE_W-1:0] cfg_min_size   = DEF_MIN_SIZE;

    // sizes near the threshold, reused to force ties
    logic [SIZE_W-1:0] size_pool [8];

    int items_queued    = 0;
    int items_taken     = 0;
    int results_checked = 0;
    int dumps_taken     = 0;
    int settings_used   = 0;
    int fail_count      = 0;
    int quiet_cycles    = 0;
    bit no_idle         = 1'b0;
    logic in_taken      = 1'b0;

    function automatic void report_fail(string what, logic [63:0] want_v, logic [63:0] got_v);
        fail_count++;
        $error("%s: expected 0x%0h, actual 0x%0h", what, want_v, got_v);
    endfunction

    function automatic void check_field(string what, logic [63:0] want_v, logic [63:0] got_v);
        if (want_v !== got_v)
            report_fail(what, want_v, got_v);
    endfunction

    // sorted insertion; ties go after the entries already held
    function automatic void offer_to_list(logic [SIZE_W-1:0] size, logic [TAG_W-1:0] tag);
        int lim;
        int pos;
        int stop;
        lim = (cfg_keep_limit > MAX_KEEP_DEF) ? MAX_KEEP_DEF : cfg_keep_limit;
        if (lim == 0 || size < cfg_min_size)
            return;
        pos = 0;
        while (pos < held_count && held_sizes[pos] >= size)
            pos++;
        if (held_count < lim) begin
            stop = held_count;
            held_count++;
        end else begin
            // full, or limit lowered below the count: only beat the smallest
            if (held_count == 0 || size <= held_sizes[held_count-1])
                return;
            stop = held_count - 1;
        end
        for (int i = stop; i > pos; i--) begin
            held_sizes[i] = held_sizes[i-1];
            held_tags[i]  = held_tags[i-1];
        end
        held_sizes[pos] = size;
        held_tags[pos]  = tag;
    endfunction

    function automatic void predict_item(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
                                         logic [TAG_W-1:0] tag);
        entry_result_t r;
        case (op)
            OP_OFFER: offer_to_list(size, tag);
            OP_CLEAR: held_count = 0;
            OP_DUMP: begin
                dumps_taken++;
                if (held_count == 0) begin
                    // empty list gives a single flagged item
                    r          = '0;
                    r.is_empty = 1'b1;
                    r.last     = 1'b1;
                    dump_results_q = {dump_results_q, r};
                end else begin
                    for (int i = 0; i < held_count; i++) begin
                        r.rank     = RANK_W'(i);
                        r.size     = held_sizes[i];
                        r.tag      = held_tags[i];
                        r.is_empty = 1'b0;
                        r.last     = (i == held_count - 1);
                        dump_results_q = {dump_results_q, r};
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // driver: a new item only once the previous one was taken
    always @(negedge aclk) begin
        if (!s_tvalid || in_taken) begin
            if (pending_items.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                next_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_item.op;
                s_tdata  <= {next_item.tag, next_item.size};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // monitor: check results first, then predict from the item taken at this edge
    always @(posedge aclk) begin
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (dump_results_q.size() == 0) begin
                report_fail("unexpected result item, m_tdata", '0, m_tdata[63:0]);
            end else begin
                want = dump_results_q.pop_front();
                check_field("rank", want.rank, m_tdata[4:0]);
                check_field("entry_size", want.size, m_tdata[52:5]);
                check_field("entry_tag", want.tag, m_tdata[84:53]);
                check_field("is_empty", want.is_empty, m_tuser[0]);
                check_field("last", want.last, m_tlast);
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            items_taken++;
            predict_item(s_tuser, s_tdata[47:0], s_tdata[79:48]);
        end
    end

    // watchdog: any handshake on either channel or the register port counts as progress
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("stalled for %0d cycles, %0d results outstanding",
                         quiet_cycles, dump_results_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [SIZE_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[SIZE_W-1:0];
    endfunction

    // base plus offset, saturating at the top of the size range
    function automatic logic [SIZE_W-1:0] bump(logic [SIZE_W-1:0] base, int unsigned off);
        logic [SIZE_W:0] s;
        s = {1'b0, base} + off;
        return s[SIZE_W] ? SIZE_MAX : s[SIZE_W-1:0];
    endfunction

    // sizes mostly around the threshold, some anywhere in range
    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return rand48();
            1:       return $urandom_range(0, 1) ? SIZE_MAX : '0;
            2:       return (cfg_min_size != 0) ? cfg_min_size - 1 : '0;
            3:       return cfg_min_size;
            4, 5, 6: return size_pool[$urandom_range(0, 7)];
            default: return bump(cfg_min_size, $urandom_range(0, 4000));
        endcase
    endfunction

    task automatic queue_item(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
                              logic [TAG_W-1:0] tag);
        tracker_item_t it;
        it.op   = op;
        it.size = size;
        it.tag  = tag;
        pending_items = {pending_items, it};
        items_queued++;
    endtask

    // sender holds back until everything queued is taken and every result is in
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (items_taken != items_queued || dump_results_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(logic idx, logic [PDATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        if (idx == REG_KEEP_LIMIT)
            cfg_keep_limit = int'(value[KL_W-1:0]);
        else
            cfg_min_size = value[SIZE_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // mostly offers with dumps in between, some clears and unused codes as noise
    task automatic random_phase(int n_items, int keep, logic [SIZE_W-1:0] min_sz,
                                bit mid_pause);
        int r;
        write_reg(REG_KEEP_LIMIT, keep);
        write_reg(REG_MIN_SIZE, min_sz);
        for (int k = 0; k < 8; k++)
            size_pool[k] = bump(cfg_min_size, $urandom_range(0, 12));
        for (int k = 0; k < n_items; k++) begin
            if (mid_pause && k == n_items / 2)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 78)
                queue_item(OP_OFFER, pick_size(), $urandom);
            else if (r < 91)
                queue_item(OP_DUMP, rand48(), $urandom);
            else if (r < 96)
                queue_item(OP_CLEAR, rand48(), $urandom);
            else
                queue_item(OP_UNUSED, pick_size(), $urandom);
        end
        queue_item(OP_DUMP, '0, '0);
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: empty dump, threshold edges, largest size, unused code
        queue_item(OP_DUMP, '0, '0);
        queue_item(OP_OFFER, DEF_MIN_SIZE - 1, 32'h0000_0001);
        queue_item(OP_OFFER, DEF_MIN_SIZE, 32'h0000_0002);
        queue_item(OP_OFFER, SIZE_MAX, 32'hFFFF_FFFF);
        queue_item(OP_UNUSED, SIZE_MAX, 32'hFFFF_FFFF);
        queue_item(OP_DUMP, '0, '0);
        queue_item(OP_CLEAR, '0, '0);
        queue_item(OP_DUMP, '0, '0);
        wait_drained();

        // small list, no threshold: fill, ties, replace the smallest only if larger
        write_reg(REG_KEEP_LIMIT, 3);
        write_reg(REG_MIN_SIZE, '0);
        queue_item(OP_OFFER, 48'd0, 32'd0);
        queue_item(OP_OFFER, 48'd5, 32'd1);
        queue_item(OP_OFFER, 48'd5, 32'd2);
        queue_item(OP_OFFER, 48'd7, 32'd3);
        queue_item(OP_OFFER, 48'd5, 32'd4);
        queue_item(OP_OFFER, 48'd6, 32'd5);
        queue_item(OP_DUMP, '0, '0);
        wait_drained();

        // limit lowered below the count: entries stay, list counts as full
        write_reg(REG_KEEP_LIMIT, 1);
        queue_item(OP_OFFER, 48'd8, 32'd6);
        queue_item(OP_OFFER, 48'd6, 32'd7);
        queue_item(OP_DUMP, '0, '0);
        wait_drained();

        // collection off: offers ignored, held list still dumps
        write_reg(REG_KEEP_LIMIT, 0);
        queue_item(OP_OFFER, SIZE_MAX, 32'd8);
        queue_item(OP_DUMP, '0, '0);
        queue_item(OP_CLEAR, '0, '0);
        queue_item(OP_DUMP, '0, '0);
        wait_drained();

        // widest list, highest threshold: only the largest size passes
        write_reg(REG_KEEP_LIMIT, MAX_KEEP_DEF);
        write_reg(REG_MIN_SIZE, SIZE_MAX);
        queue_item(OP_OFFER, SIZE_MAX - 1, 32'd9);
        queue_item(OP_OFFER, SIZE_MAX, 32'hFFFF_FFFF);
        queue_item(OP_OFFER, SIZE_MAX, 32'd0);
        queue_item(OP_DUMP, '0, '0);
        wait_drained();

        // random part over several settings
        random_phase(30, MAX_KEEP_DEF, '0, 1'b0);
        no_idle = 1'b1;
        random_phase(40, int'(DEF_KEEP_LIMIT), DEF_MIN_SIZE, 1'b0);
        no_idle = 1'b0;
        random_phase(40, 5, rand48(), 1'b1);
        random_phase(40, 63, 48'($urandom_range(0, 1000)), 1'b0);
        random_phase(30, 1, '0, 1'b0);
        random_phase(15, 0, '0, 1'b0);
        random_phase(35, $urandom_range(2, 40), bump(48'd0, $urandom), 1'b1);

        repeat (FINAL_CYCLES) @(posedge aclk);
        $display("%0d items taken under %0d register writes, %0d dumps",
                 items_taken, settings_used, dumps_taken);
        $display("%0d result items checked, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0 && dump_results_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
